// ===== rtl/keyed_value_extractor_top_assert.svh =====
// assertion macros for the keyed value extractor
// used by keyed_value_extractor_top, expects clk and rst_n in scope
`ifndef KEYED_VALUE_EXTRACTOR_TOP_ASSERT_SVH
`define KEYED_VALUE_EXTRACTOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define KVE_ASSERT_IMP(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);
`define KVE_ASSERT_NXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);
`else
`define KVE_ASSERT_IMP(lbl, ant, cons, msg)
`define KVE_ASSERT_NXT(lbl, ant, cons, msg)
`endif

`endif

// ===== rtl/kve_pkg.sv =====
// shared types and constants for the keyed value extractor
// no dependencies
package kve_pkg;

  localparam int SKIP_BYTES = 2;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LEN  = 2'd0,
    CFG_KEY_LOW  = 2'd1,
    CFG_KEY_HIGH = 2'd2,
    CFG_END_CHAR = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_SKIP   = 2'd1,
    PH_VALUE  = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_VALUE     = 3'd0,
    ST_END       = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_TRUNC     = 3'd4
  } status_t;

endpackage

// ===== rtl/kve_in_if.sv =====
// input byte channel of the keyed value extractor
// no dependencies
interface kve_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface

// ===== rtl/kve_out_if.sv =====
// result channel of the keyed value extractor
// no dependencies
interface kve_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       value_last;

  modport source (output valid, output out_byte, output status, output value_last,
                  input ready);
  modport sink (input valid, input out_byte, input status, input value_last,
                output ready);
endinterface

// ===== rtl/keyed_value_extractor_top.sv =====
// keyed value extractor; any result is valid the cycle after its byte is taken
// a single output register parts the channels; in ready = output empty or taken
// one byte/cycle while in ready, set by single-pass key compare and phase logic
// synchronous active-low reset clears phase, byte count, config; key length to 1
// depends on kve_pkg, kve_in_if, kve_out_if, keyed_value_extractor_top_assert.svh
`include "keyed_value_extractor_top_assert.svh"

module keyed_value_extractor_top
  import kve_pkg::*;
#(
  parameter int KEY_MAX = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  kve_in_if.sink                in_ch,
  kve_out_if.source             out_ch
);

  localparam int CNT_W = $clog2(KEY_MAX + 1);

  logic [4:0]       key_len_r;
  logic [63:0]      key_low_r;
  logic [63:0]      key_high_r;
  logic [7:0]       end_char_r;

  logic [7:0]       win_r [KEY_MAX];
  logic [7:0]       win_nxt [KEY_MAX];
  logic [CNT_W-1:0] seen_r, seen_nxt;
  phase_t           phase_r, phase_nxt;
  logic [1:0]       skip_r, skip_nxt, skip_inc;
  logic             first_r, first_nxt;

  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  status_t          status_r;
  logic             last_r;

  logic [7:0]       key_b [16];
  logic [KEY_MAX-1:0] align_hit;
  logic [KEY_MAX-1:0] len_hit;
  logic             key_hit;
  logic             in_acc;
  logic             is_end_char;

  logic             res_valid;
  logic [7:0]       res_byte;
  status_t          res_status;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_end_char = (in_ch.data_byte == end_char_r);
  assign skip_inc    = skip_r + 2'd1;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r  <= 5'd1;
      key_low_r  <= '0;
      key_high_r <= '0;
      end_char_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KEY_LEN:  key_len_r  <= cfg_wdata[4:0];
        CFG_KEY_LOW:  key_low_r  <= cfg_wdata;
        CFG_KEY_HIGH: key_high_r <= cfg_wdata;
        CFG_END_CHAR: end_char_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      key_b[k]     = key_low_r[8*k +: 8];
      key_b[k + 8] = key_high_r[8*k +: 8];
    end
  end

  // shifted window and byte count
  always_comb begin
    win_nxt[0] = in_ch.data_byte;
    for (int j = 1; j < KEY_MAX; j++) begin
      win_nxt[j] = win_r[j-1];
    end
    seen_nxt = (seen_r == CNT_W'(KEY_MAX)) ? seen_r : seen_r + CNT_W'(1);
  end

  // key compare at every alignment, picked by key length
  always_comb begin
    for (int l = 1; l <= KEY_MAX; l++) begin
      align_hit[l-1] = (seen_nxt >= CNT_W'(l));
      for (int i = 0; i < l; i++) begin
        if (win_nxt[l-1-i] != key_b[i]) begin
          align_hit[l-1] = 1'b0;
        end
      end
      len_hit[l-1] = (key_len_r == 5'(l)) ||
                     ((l == KEY_MAX) && (key_len_r > 5'(KEY_MAX)));
    end
    key_hit = |(align_hit & len_hit);
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    skip_nxt  = skip_r;
    first_nxt = first_r;
    unique case (phase_r)
      PH_SEARCH: begin
        if (key_hit && !in_ch.buffer_end) begin
          phase_nxt = PH_SKIP;
          skip_nxt  = 2'd0;
        end
      end
      PH_SKIP: begin
        if (!in_ch.buffer_end) begin
          skip_nxt = skip_inc;
          if (skip_inc >= 2'(SKIP_BYTES)) begin
            phase_nxt = PH_VALUE;
          end
        end
      end
      PH_VALUE: begin
        if (is_end_char) begin
          phase_nxt = PH_DONE;
        end else if (!in_ch.buffer_end) begin
          first_nxt = 1'b0;
        end
      end
      PH_DONE: ;
      default: ;
    endcase
    if (in_ch.buffer_end) begin
      phase_nxt = PH_SEARCH;
      skip_nxt  = 2'd0;
      first_nxt = 1'b1;
    end
  end

  // result for this byte
  always_comb begin
    res_valid  = 1'b0;
    res_byte   = 8'd0;
    res_status = ST_NOT_FOUND;
    unique case (phase_r)
      PH_SEARCH: begin
        if (in_ch.buffer_end) begin
          res_valid  = 1'b1;
          res_status = key_hit ? ST_TRUNC : ST_NOT_FOUND;
        end
      end
      PH_SKIP: begin
        if (in_ch.buffer_end) begin
          res_valid  = 1'b1;
          res_status = ST_TRUNC;
        end
      end
      PH_VALUE: begin
        res_valid = 1'b1;
        if (is_end_char) begin
          res_status = first_r ? ST_EMPTY : ST_END;
          res_byte   = first_r ? 8'd0 : in_ch.data_byte;
        end else if (in_ch.buffer_end) begin
          res_status = ST_TRUNC;
        end else begin
          res_status = ST_VALUE;
          res_byte   = in_ch.data_byte;
        end
      end
      PH_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      seen_r  <= '0;
      skip_r  <= '0;
      first_r <= 1'b1;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      skip_r  <= skip_nxt;
      first_r <= first_nxt;
      if (in_ch.buffer_end) begin
        seen_r <= '0;
      end else if (phase_r == PH_SEARCH) begin
        seen_r <= seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && phase_r == PH_SEARCH) begin
      for (int j = 0; j < KEY_MAX; j++) begin
        win_r[j] <= win_nxt[j];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= res_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_byte_r <= res_byte;
      status_r   <= res_status;
      last_r     <= (res_status != ST_VALUE);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.status     = status_r;
  assign out_ch.value_last = last_r;

  `KVE_ASSERT_IMP(a_last_matches_status, out_valid_r,
    (status_r == ST_VALUE) == !last_r, "value_last disagrees with status")
  `KVE_ASSERT_IMP(a_zero_byte_on_report,
    out_valid_r && status_r != ST_VALUE && status_r != ST_END,
    out_byte_r == 8'd0, "report word carries a nonzero byte")
  `KVE_ASSERT_NXT(a_clear_after_end, in_acc && in_ch.buffer_end,
    phase_r == PH_SEARCH && seen_r == '0 && first_r, "state not cleared after buffer end")
  `KVE_ASSERT_IMP(a_skip_bounded, phase_r == PH_SKIP,
    skip_r < 2'(SKIP_BYTES), "skip count overran")

endmodule
